// File: rtl/dsio_pkg.sv
// Shared constants, types and decode helpers for the display/solenoid I/O block.
package dsio_pkg;

    localparam int unsigned AddrW    = 16;
    localparam int unsigned DataW    = 8;
    localparam int unsigned SolW     = 24;
    localparam int unsigned ToneW    = 8;
    localparam int unsigned SegW     = 10;
    localparam int unsigned PosW     = 4;
    localparam int unsigned NumDigit = 5;

    typedef logic [AddrW-1:0] t_addr;
    typedef logic [DataW-1:0] t_data;
    typedef logic [SolW-1:0]  t_sol;
    typedef logic [ToneW-1:0] t_tone;
    typedef logic [SegW-1:0]  t_seg;
    typedef logic [PosW-1:0]  t_pos;

    // Item kinds carried on the mode bit
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Bus decode
    localparam t_addr ADDR_STROBE     = 16'h00AB;
    localparam t_addr ADDR_DIGIT_BASE = 16'h0200;
    localparam t_addr ADDR_DIGIT_LAST = 16'h0204;
    localparam t_addr ADDR_SOL_PULSE  = 16'h0310;
    localparam t_addr ADDR_SOUND      = 16'h0320;
    localparam t_addr ADDR_LAMP_ROW0  = 16'h0330;

    // Solenoid group masks
    localparam t_sol SOL_KEEP_HIGH = 24'hFFFF00;
    localparam t_sol SOL_KEEP_LOW  = 24'h000FFF;
    localparam t_sol SOL_KEEP_LAMP = 24'hFFFCFF;
    localparam t_sol SOL_KNOCKER   = 24'h001000;
    localparam int unsigned ToneBase = 16;

    localparam logic [1:0] PULSE_LAST = 2'd3;
    localparam logic [2:0] SOUND_LAST = 3'd5;

    // Strobe highest-bit index (0 = no bit set) to display position
    function automatic t_pos strobe_pos(input logic [3:0] idx);
        t_pos pos;
        unique case (idx)
            4'd0:    pos = 4'd0;
            4'd1:    pos = 4'd6;
            4'd2:    pos = 4'd7;
            4'd3:    pos = 4'd8;
            4'd4:    pos = 4'd5;
            4'd5:    pos = 4'd4;
            4'd6:    pos = 4'd2;
            4'd7:    pos = 4'd9;
            4'd8:    pos = 4'd3;
            4'd9:    pos = 4'd1;
            default: pos = 4'd0;
        endcase
        return pos;
    endfunction

    // 0 for zero data, else 1 + index of highest set bit
    function automatic logic [3:0] strobe_idx(input t_data d);
        logic [3:0] idx;
        idx = 4'd0;
        for (int i = 0; i < DataW; i++) begin
            if (d[i]) idx = 4'(i + 1);
        end
        return idx;
    endfunction

    // Bit 7 of a digit write fans out to segment bits 8 and 9
    function automatic t_seg digit_word(input t_data d);
        return {d[7], d[7], 1'b0, d[6:0]};
    endfunction

endpackage

// File: rtl/dsio_in_if.sv
// Input channel: bus writes and refresh ticks.
interface dsio_in_if;
    logic                 valid;
    logic                 ready;
    logic                 mode;
    dsio_pkg::t_addr      address;
    dsio_pkg::t_data      write_data;

    modport source (output valid, output mode, output address, output write_data,
                    input ready);
    modport sink   (input valid, input mode, input address, input write_data,
                    output ready);
endinterface

// File: rtl/dsio_out_if.sv
// Output channel: solenoid, tone and display words after each item.
interface dsio_out_if;
    logic                 valid;
    logic                 ready;
    dsio_pkg::t_sol       solenoid_bits;
    dsio_pkg::t_tone      tone_enable;
    logic                 segment_valid;
    dsio_pkg::t_pos       segment_position;
    dsio_pkg::t_seg       row0_segments;
    dsio_pkg::t_seg       row1_segments;
    dsio_pkg::t_seg       row2_segments;
    dsio_pkg::t_seg       row3_segments;
    dsio_pkg::t_seg       row4_segments;

    modport source (output valid, output solenoid_bits, output tone_enable,
                    output segment_valid, output segment_position,
                    output row0_segments, output row1_segments, output row2_segments,
                    output row3_segments, output row4_segments,
                    input ready);
    modport sink   (input valid, input solenoid_bits, input tone_enable,
                    input segment_valid, input segment_position,
                    input row0_segments, input row1_segments, input row2_segments,
                    input row3_segments, input row4_segments,
                    output ready);
endinterface

// File: rtl/display_solenoid_io_block_core.sv
// Display/solenoid I/O block: bus write decode, refresh timeouts, result register.
// An input transfer's result is registered and shows on o_out in the next cycle.
// Throughput: one item per cycle; a new item is taken whenever the result
// register is empty or its result is transferred in the same cycle.
// Reset (i_rst_n low, synchronous): digit latches, solenoid word, tones and
// both tick counters clear; the result register empties.
module display_solenoid_io_block_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dsio_in_if.sink           i_in,
    dsio_out_if.source        o_out
);

    // ---------------------------------------------------------------
    // Architectural state
    // ---------------------------------------------------------------
    dsio_pkg::t_seg  r_digit [dsio_pkg::NumDigit];
    dsio_pkg::t_sol  r_sol;
    dsio_pkg::t_tone r_tone;
    logic [1:0]      r_pulse_cnt;
    logic [2:0]      r_sound_cnt;

    dsio_pkg::t_seg  n_digit [dsio_pkg::NumDigit];
    dsio_pkg::t_sol  n_sol;
    dsio_pkg::t_tone n_tone;
    logic [1:0]      n_pulse_cnt;
    logic [2:0]      n_sound_cnt;
    logic            n_seg_valid;
    dsio_pkg::t_pos  n_seg_pos;

    // Result register
    logic            r_out_valid;
    dsio_pkg::t_sol  r_out_sol;
    dsio_pkg::t_tone r_out_tone;
    logic            r_out_seg_valid;
    dsio_pkg::t_pos  r_out_seg_pos;
    dsio_pkg::t_seg  r_out_row [dsio_pkg::NumDigit];

    logic            in_xfer;

    // Take a new item when the result slot is free or drains this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    // ---------------------------------------------------------------
    // Next-state decode for one item
    // ---------------------------------------------------------------
    always_comb begin
        logic [1:0] pulse_inc;
        for (int i = 0; i < dsio_pkg::NumDigit; i++) begin
            n_digit[i] = r_digit[i];
        end
        n_sol       = r_sol;
        n_tone      = r_tone;
        n_pulse_cnt = r_pulse_cnt;
        n_sound_cnt = r_sound_cnt;
        n_seg_valid = 1'b0;
        n_seg_pos   = '0;
        pulse_inc   = r_pulse_cnt + 2'd1;

        if (i_in.mode == dsio_pkg::MODE_TICK) begin
            // Low group drops once the 2-bit pulse counter wraps
            n_pulse_cnt = pulse_inc;
            if (pulse_inc == 2'd0) begin
                n_sol = n_sol & dsio_pkg::SOL_KEEP_HIGH;
            end
            // Sound timeout: high group and tones drop after six ticks
            if (r_sound_cnt >= dsio_pkg::SOUND_LAST) begin
                n_sound_cnt = 3'd0;
                n_sol       = n_sol & dsio_pkg::SOL_KEEP_LOW;
                n_tone      = '0;
            end else begin
                n_sound_cnt = r_sound_cnt + 3'd1;
            end
        end else begin
            priority if (i_in.address == dsio_pkg::ADDR_STROBE) begin
                n_seg_valid = 1'b1;
                n_seg_pos   = dsio_pkg::strobe_pos(dsio_pkg::strobe_idx(i_in.write_data));
            end else if (i_in.address >= dsio_pkg::ADDR_DIGIT_BASE &&
                         i_in.address <= dsio_pkg::ADDR_DIGIT_LAST) begin
                n_digit[i_in.address[2:0]] = dsio_pkg::digit_word(i_in.write_data);
            end else if (i_in.address == dsio_pkg::ADDR_SOL_PULSE) begin
                n_pulse_cnt = 2'd0;
                // Solenoid numbers past the word are dropped
                if (i_in.write_data < 8'(dsio_pkg::SolW)) begin
                    n_sol[i_in.write_data[4:0]] = 1'b1;
                end
            end else if (i_in.address == dsio_pkg::ADDR_SOUND) begin
                n_sound_cnt = 3'd0;
                if (i_in.write_data < 8'(dsio_pkg::ToneW)) begin
                    n_sol       = {8'd0, r_sol[15:0]};
                    n_sol[5'(dsio_pkg::ToneBase) + 5'(i_in.write_data[2:0])] = 1'b1;
                    n_tone      = '0;
                    n_tone[i_in.write_data[2:0]] = 1'b1;
                end else begin
                    // Knocker
                    n_sol = r_sol | dsio_pkg::SOL_KNOCKER;
                end
            end else if (i_in.address == dsio_pkg::ADDR_LAMP_ROW0) begin
                n_sol = (r_sol & dsio_pkg::SOL_KEEP_LAMP) |
                        {14'd0, i_in.write_data[1:0], 8'd0};
            end else begin
                // unmapped: no effect
            end
        end
    end

    // ---------------------------------------------------------------
    // State registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dsio_pkg::NumDigit; i++) begin
                r_digit[i] <= '0;
            end
            r_sol       <= '0;
            r_tone      <= '0;
            r_pulse_cnt <= '0;
            r_sound_cnt <= '0;
        end else if (in_xfer) begin
            for (int i = 0; i < dsio_pkg::NumDigit; i++) begin
                r_digit[i] <= n_digit[i];
            end
            r_sol       <= n_sol;
            r_tone      <= n_tone;
            r_pulse_cnt <= n_pulse_cnt;
            r_sound_cnt <= n_sound_cnt;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_sol       <= n_sol;
            r_out_tone      <= n_tone;
            r_out_seg_valid <= n_seg_valid;
            r_out_seg_pos   <= n_seg_pos;
            for (int i = 0; i < dsio_pkg::NumDigit; i++) begin
                r_out_row[i] <= n_digit[i];
            end
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.solenoid_bits    = r_out_sol;
    assign o_out.tone_enable      = r_out_tone;
    assign o_out.segment_valid    = r_out_seg_valid;
    assign o_out.segment_position = r_out_seg_pos;
    assign o_out.row0_segments    = r_out_row[0];
    assign o_out.row1_segments    = r_out_row[1];
    assign o_out.row2_segments    = r_out_row[2];
    assign o_out.row3_segments    = r_out_row[3];
    assign o_out.row4_segments    = r_out_row[4];

`ifndef SYNTHESIS
    // Sound counter never leaves 0..5
    a_sound_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sound_cnt <= dsio_pkg::SOUND_LAST)
        else $error("sound tick counter out of range");

    // At most one tone is ever enabled
    a_tone_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_tone))
        else $error("more than one tone enabled");

    // A position is only reported alongside a strobe
    a_seg_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_seg_valid |-> r_out_seg_pos == '0)
        else $error("segment position without strobe");

    // Pulse write restarts the pulse timeout
    a_pulse_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in.mode == dsio_pkg::MODE_WRITE &&
        i_in.address == dsio_pkg::ADDR_SOL_PULSE |=> r_pulse_cnt == 2'd0)
        else $error("pulse counter not restarted");
`endif

endmodule
